[rtl/nearest_template_classifier_assert.svh]
// assertion macros for the rtl
`ifndef NEAREST_TEMPLATE_CLASSIFIER_ASSERT_SVH
`define NEAREST_TEMPLATE_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define NTC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntc assertion failed");

// next-cycle implication
`define NTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntc assertion failed");

`endif

[rtl/ntc_pkg.sv]
package ntc_pkg;

   localparam int NUM_CLASSES     = 10;
   localparam int SLOTS_PER_CLASS = 64;
   localparam int NUM_DIMS        = 25;
   localparam int FEATURE_BITS    = 16;

   // port widths
   localparam int CMD_W      = 2;
   localparam int CLASS_ID_W = 4;
   localparam int SLOT_ID_W  = 6;
   localparam int DIM_ID_W   = 5;
   localparam int VALUE_W    = 16;
   localparam int COUNT_W    = 7;

   // internal widths
   localparam int FEAT_W     = FEATURE_BITS;
   localparam int SQ_W       = 2 * FEAT_W;
   localparam int DIST_W     = SQ_W + $clog2(NUM_DIMS);
   localparam int CLS_W      = $clog2(NUM_CLASSES);
   localparam int SLOT_W     = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
   localparam int CNT_W      = $clog2(SLOTS_PER_CLASS + 1);
   localparam int DIM_W      = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
   localparam int TMPL_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS * NUM_DIMS;
   localparam int ADDR_W     = $clog2(TMPL_DEPTH);

   localparam logic [CMD_W-1:0] CMD_TMPL_WR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMP_WR   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT_SET = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLASSIFY  = 2'd3;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [CLS_W-1:0]  cls;
      logic [SLOT_W-1:0] slot;
   } issue_type;

   typedef struct packed {
      logic             we;
      logic [CLS_W-1:0] cls;
      logic [CNT_W-1:0] value;
   } cnt_wr_type;

   typedef struct packed {
      logic              found;
      logic [CLS_W-1:0]  cls;
      logic [SLOT_W-1:0] slot;
      logic [DIST_W-1:0] distance;
   } result_type;

   function automatic logic [ADDR_W-1:0] tmpl_addr(input logic [CLS_W-1:0] cls,
                                                   input logic [SLOT_W-1:0] slot,
                                                   input logic [DIM_W-1:0] dim);
      int row;
      row = int'(cls) * SLOTS_PER_CLASS + int'(slot);
      return ADDR_W'(row * NUM_DIMS + int'(dim));
   endfunction

endpackage

[rtl/ntc_store.sv]
module ntc_store (
   input  logic                             clock,
   input  logic                             tmpl_we,
   input  logic [ntc_pkg::ADDR_W-1:0]       tmpl_waddr,
   input  logic                             samp_we,
   input  logic [ntc_pkg::DIM_W-1:0]        samp_wdim,
   input  logic [ntc_pkg::FEAT_W-1:0]       wdata,
   input  logic [ntc_pkg::ADDR_W-1:0]       tmpl_raddr,
   input  logic [ntc_pkg::DIM_W-1:0]        samp_rdim,
   output logic [ntc_pkg::FEAT_W-1:0]       tmpl_rd,
   output logic [ntc_pkg::FEAT_W-1:0]       samp_rd
);

   logic [ntc_pkg::FEAT_W-1:0] tmpl_mem [ntc_pkg::TMPL_DEPTH];
   logic [ntc_pkg::FEAT_W-1:0] samp_mem [ntc_pkg::NUM_DIMS];
   logic [ntc_pkg::FEAT_W-1:0] tmpl_rd_ff;
   logic [ntc_pkg::FEAT_W-1:0] samp_rd_ff;

   always_ff @(posedge clock) begin
      if (tmpl_we) begin
         tmpl_mem[tmpl_waddr] <= wdata;
      end
      tmpl_rd_ff <= tmpl_mem[tmpl_raddr];
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem[samp_wdim] <= wdata;
      end
      samp_rd_ff <= samp_mem[samp_rdim];
   end

   assign tmpl_rd = tmpl_rd_ff;
   assign samp_rd = samp_rd_ff;

endmodule

[rtl/ntc_scan.sv]
module ntc_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  ntc_pkg::cnt_wr_type         cnt_wr,
   input  logic                        start,
   input  logic                        run,
   output ntc_pkg::issue_type          issue,
   output logic [ntc_pkg::ADDR_W-1:0]  tmpl_raddr,
   output logic [ntc_pkg::DIM_W-1:0]   samp_rdim,
   output logic                        done
);

   logic [ntc_pkg::CNT_W-1:0] count_ff [ntc_pkg::NUM_CLASSES];
   logic [ntc_pkg::CLS_W-1:0] cls_ff, cls_in;
   logic [ntc_pkg::CNT_W-1:0] slot_ff, slot_in;
   logic [ntc_pkg::DIM_W-1:0] dim_ff, dim_in;
   logic [ntc_pkg::CNT_W-1:0] cur_count;
   logic                      slot_end;
   logic                      last_cls;
   logic                      dim_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ntc_pkg::NUM_CLASSES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (cnt_wr.we) begin
         count_ff[cnt_wr.cls] <= cnt_wr.value;
      end
   end

   assign cur_count = count_ff[cls_ff];
   assign slot_end  = (slot_ff == cur_count);
   assign last_cls  = (cls_ff == ntc_pkg::CLS_W'(ntc_pkg::NUM_CLASSES - 1));
   assign dim_last  = (dim_ff == ntc_pkg::DIM_W'(ntc_pkg::NUM_DIMS - 1));

   always_comb begin
      issue.valid = run && !slot_end;
      issue.last  = dim_last;
      issue.cls   = cls_ff;
      issue.slot  = slot_ff[ntc_pkg::SLOT_W-1:0];
      done        = run && slot_end && last_cls;
   end

   assign tmpl_raddr = ntc_pkg::tmpl_addr(cls_ff, slot_ff[ntc_pkg::SLOT_W-1:0], dim_ff);
   assign samp_rdim  = dim_ff;

   always_comb begin
      cls_in  = cls_ff;
      slot_in = slot_ff;
      dim_in  = dim_ff;
      if (start) begin
         cls_in  = '0;
         slot_in = '0;
         dim_in  = '0;
      end else if (run) begin
         if (slot_end) begin
            if (!last_cls) begin
               cls_in  = cls_ff + 1'b1;
               slot_in = '0;
               dim_in  = '0;
            end
         end else if (dim_last) begin
            dim_in  = '0;
            slot_in = slot_ff + 1'b1;
         end else begin
            dim_in = dim_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff  <= '0;
         slot_ff <= '0;
         dim_ff  <= '0;
      end else begin
         cls_ff  <= cls_in;
         slot_ff <= slot_in;
         dim_ff  <= dim_in;
      end
   end

endmodule

[rtl/ntc_dist_unit.sv]
module ntc_dist_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  ntc_pkg::issue_type          issue,
   input  logic [ntc_pkg::FEAT_W-1:0]  tmpl_rd,
   input  logic [ntc_pkg::FEAT_W-1:0]  samp_rd,
   output ntc_pkg::result_type         best,
   output logic                        busy
);

   ntc_pkg::issue_type         tag1_ff, tag2_ff, tag3_ff;
   logic [ntc_pkg::FEAT_W-1:0] diff_ff;
   logic [ntc_pkg::SQ_W-1:0]   sq_ff;
   logic [ntc_pkg::DIST_W-1:0] acc_ff;
   logic [ntc_pkg::DIST_W-1:0] acc_in;
   logic [ntc_pkg::DIST_W-1:0] dist_ff;
   logic [ntc_pkg::CLS_W-1:0]  dist_cls_ff;
   logic [ntc_pkg::SLOT_W-1:0] dist_slot_ff;
   logic                       done_ff;
   ntc_pkg::result_type        best_ff;

   // tag follows the memory read, difference and square registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag1_ff <= issue;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         done_ff <= tag3_ff.valid && tag3_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= (tmpl_rd >= samp_rd) ? (tmpl_rd - samp_rd) : (samp_rd - tmpl_rd);
      sq_ff   <= ntc_pkg::SQ_W'(diff_ff) * ntc_pkg::SQ_W'(diff_ff);
   end

   assign acc_in = acc_ff + ntc_pkg::DIST_W'(sq_ff);

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
      end else if (tag3_ff.valid) begin
         if (tag3_ff.last) begin
            acc_ff <= '0;
         end else begin
            acc_ff <= acc_in;
         end
      end
      if (tag3_ff.valid && tag3_ff.last) begin
         dist_ff      <= acc_in;
         dist_cls_ff  <= tag3_ff.cls;
         dist_slot_ff <= tag3_ff.slot;
      end
   end

   // strictly smaller keeps the first of equal distances
   always_ff @(posedge clock) begin
      if (reset || start) begin
         best_ff <= '0;
      end else if (done_ff && (!best_ff.found || dist_ff < best_ff.distance)) begin
         best_ff.found    <= 1'b1;
         best_ff.cls      <= dist_cls_ff;
         best_ff.slot     <= dist_slot_ff;
         best_ff.distance <= dist_ff;
      end
   end

   assign best = best_ff;
   assign busy = tag1_ff.valid || tag2_ff.valid || tag3_ff.valid || done_ff;

endmodule

[rtl/nearest_template_classifier.sv]
// Nearest-template classifier. Load words (template feature write, sample feature write,
// class count set) are taken one per cycle while idle and give no result. A classify word
// walks every loaded template, class ascending then slot ascending, one feature per cycle
// through a single subtract-square-accumulate unit fed by the template memory's one read
// port; it cannot finish while an earlier result still waits in the output register, and
// req_ready is low throughout. The result (nearest class, slot, squared distance, found
// flag) sits in an output register; load words are taken while it waits.
`include "nearest_template_classifier_assert.svh"

module nearest_template_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ntc_pkg::CMD_W-1:0]          req_cmd,
   input  logic [ntc_pkg::CLASS_ID_W-1:0]     req_class_id,
   input  logic [ntc_pkg::SLOT_ID_W-1:0]      req_slot,
   input  logic [ntc_pkg::DIM_ID_W-1:0]       req_dim,
   input  logic [ntc_pkg::VALUE_W-1:0]        req_value,
   input  logic [ntc_pkg::COUNT_W-1:0]        req_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ntc_pkg::CLASS_ID_W-1:0]     rsp_best_class,
   output logic [ntc_pkg::SLOT_ID_W-1:0]      rsp_best_slot,
   output logic [ntc_pkg::DIST_W-1:0]         rsp_best_distance,
   output logic                               rsp_found
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic                       accept;
   logic                       cls_ok, slot_ok, dim_ok;
   logic                       tmpl_we, samp_we;
   logic [ntc_pkg::ADDR_W-1:0] tmpl_waddr;
   logic [ntc_pkg::ADDR_W-1:0] tmpl_raddr;
   logic [ntc_pkg::DIM_W-1:0]  samp_rdim;
   logic [ntc_pkg::FEAT_W-1:0] tmpl_rd, samp_rd;
   ntc_pkg::cnt_wr_type        cnt_wr;
   ntc_pkg::issue_type         issue;
   ntc_pkg::result_type        best;
   logic                       start;
   logic                       run;
   logic                       scan_done;
   logic                       busy;
   logic                       load_rsp;
   logic                       rsp_valid_ff;
   ntc_pkg::result_type        rsp_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign cls_ok  = 32'(req_class_id) < ntc_pkg::NUM_CLASSES;
   assign slot_ok = 32'(req_slot) < ntc_pkg::SLOTS_PER_CLASS;
   assign dim_ok  = 32'(req_dim) < ntc_pkg::NUM_DIMS;

   assign tmpl_we = accept && (req_cmd == ntc_pkg::CMD_TMPL_WR) && cls_ok && slot_ok && dim_ok;
   assign samp_we = accept && (req_cmd == ntc_pkg::CMD_SAMP_WR) && dim_ok;
   assign tmpl_waddr = ntc_pkg::tmpl_addr(ntc_pkg::CLS_W'(req_class_id),
                                          ntc_pkg::SLOT_W'(req_slot),
                                          ntc_pkg::DIM_W'(req_dim));

   always_comb begin
      cnt_wr.we  = accept && (req_cmd == ntc_pkg::CMD_COUNT_SET) && cls_ok;
      cnt_wr.cls = ntc_pkg::CLS_W'(req_class_id);
      if (32'(req_count) > ntc_pkg::SLOTS_PER_CLASS) begin
         cnt_wr.value = ntc_pkg::CNT_W'(ntc_pkg::SLOTS_PER_CLASS);
      end else begin
         cnt_wr.value = ntc_pkg::CNT_W'(req_count);
      end
   end

   assign start    = accept && (req_cmd == ntc_pkg::CMD_CLASSIFY);
   assign run      = (state_ff == S_SCAN);
   assign load_rsp = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   ntc_store u_store (
      .clock      (clock),
      .tmpl_we    (tmpl_we),
      .tmpl_waddr (tmpl_waddr),
      .samp_we    (samp_we),
      .samp_wdim  (ntc_pkg::DIM_W'(req_dim)),
      .wdata      (ntc_pkg::FEAT_W'(req_value)),
      .tmpl_raddr (tmpl_raddr),
      .samp_rdim  (samp_rdim),
      .tmpl_rd    (tmpl_rd),
      .samp_rd    (samp_rd)
   );

   ntc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .cnt_wr     (cnt_wr),
      .start      (start),
      .run        (run),
      .issue      (issue),
      .tmpl_raddr (tmpl_raddr),
      .samp_rdim  (samp_rdim),
      .done       (scan_done)
   );

   ntc_dist_unit u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .issue   (issue),
      .tmpl_rd (tmpl_rd),
      .samp_rd (samp_rd),
      .best    (best),
      .busy    (busy)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= best;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_class    = ntc_pkg::CLASS_ID_W'(rsp_ff.cls);
   assign rsp_best_slot     = ntc_pkg::SLOT_ID_W'(rsp_ff.slot);
   assign rsp_best_distance = rsp_ff.distance;
   assign rsp_found         = rsp_ff.found;

   `NTC_ASSERT_IMP(a_issue_in_scan, clock, reset, issue.valid, state_ff == S_SCAN)
   `NTC_ASSERT_IMP(a_finish_drained, clock, reset, state_ff == S_FINISH, !busy)
   `NTC_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FINISH)
   `NTC_ASSERT_NEXT(a_classify_scans, clock, reset, start, state_ff == S_SCAN)

endmodule
